// ===== src/hss_pkg.sv =====
package hss_pkg;

  localparam int PATTERN_MAX_DEF = 64;
  localparam int TEXT_MAX_DEF = 4096;

  localparam int STATUS_W = 2;
  localparam int INDEX_W = 12;
  localparam int BYTE_W = 8;
  localparam int ALPHABET = 256;

  localparam logic [STATUS_W-1:0] STATUS_FOUND = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ERROR = 2'd2;

  localparam logic KIND_PATTERN = 1'b0;
  localparam logic KIND_TEXT = 1'b1;

endpackage

// ===== src/horspool_substring_search_unit.sv =====
// Horspool substring search unit.
// Input channel (in_valid / in_stall): one byte per request. kind selects
// pattern or text, last closes the pattern or the text. Pattern and text
// bytes are stored as they are accepted; the shift table is built on the fly
// as pattern bytes arrive, so closing a pattern costs nothing extra.
// A text byte with last set starts the search. in_stall stays high until
// the search is done and its result is in the output register.
// Search steps: a start state, then per window a check state, a read and a
// compare state for each byte compared and an advance state by the table
// shift, and a done state that loads the result. Every compare step reads
// one text byte and one pattern byte from registered-read memories.
// Output channel (out_valid / out_stall): one result (status, match_index)
// per search. The result is held in an output register while out_stall is
// high; bytes of the next pattern or text are accepted meanwhile, but a new
// search waits in its final state until the register is free.
// Reset clears counters, the pattern-complete flag, the shift-present bits
// and out_valid; in_stall is low from the first cycle after reset.
// Memory contents are left as they are.
module horspool_substring_search_unit #(
  parameter int PATTERN_MAX = hss_pkg::PATTERN_MAX_DEF,
  parameter int TEXT_MAX = hss_pkg::TEXT_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         kind,
  input  logic [hss_pkg::BYTE_W-1:0]   byte_value,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hss_pkg::STATUS_W-1:0] status,
  output logic [hss_pkg::INDEX_W-1:0]  match_index
);

  localparam int PA_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int TA_W = $clog2(TEXT_MAX);
  localparam int CNT_W = $clog2(PATTERN_MAX + 2);
  localparam int TC_W = $clog2(TEXT_MAX + 1);
  localparam int POS_W = $clog2(TEXT_MAX + PATTERN_MAX + 1);
  localparam int IX_W = (POS_W > hss_pkg::INDEX_W) ? POS_W : hss_pkg::INDEX_W;
  localparam int BW = hss_pkg::BYTE_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_CHK = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_CMP = 3'd4;
  localparam logic [2:0] S_ADV = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state;
  logic [CNT_W-1:0] pcount;
  logic [TC_W-1:0] tcount;
  logic complete;
  logic overflow;
  logic [BW-1:0] prev_byte;
  logic [hss_pkg::ALPHABET-1:0] present;

  logic [POS_W-1:0] pos;
  logic [CNT_W-1:0] k;
  logic [BW-1:0] tc;
  logic [hss_pkg::STATUS_W-1:0] res_status;
  logic [hss_pkg::INDEX_W-1:0] res_index;

  logic acc;
  logic [CNT_W-1:0] pbase;
  logic pat_we;
  logic shift_we;
  logic text_we;
  logic out_free;

  logic [POS_W-1:0] text_raddr_w;
  logic [CNT_W-1:0] pat_raddr_w;
  logic [BW-1:0] text_rd;
  logic [BW-1:0] pat_rd;
  logic [PA_W-1:0] shift_rd;
  logic [CNT_W-1:0] shift_val;
  logic [IX_W-1:0] index_w;
  logic cmp_re;

  assign in_stall = (state != S_IDLE);
  assign acc = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // a closed pattern is discarded by the next pattern byte
  assign pbase = complete ? '0 : pcount;
  assign pat_we = acc && (kind == hss_pkg::KIND_PATTERN) && (pbase < CNT_W'(PATTERN_MAX));
  assign shift_we = pat_we && (pbase != '0);
  assign text_we = acc && (kind == hss_pkg::KIND_TEXT) && (tcount < TC_W'(TEXT_MAX));

  assign text_raddr_w = pos - POS_W'(k);
  assign pat_raddr_w = pcount - CNT_W'(1) - k;
  assign cmp_re = (state == S_CMP) && (k == '0);
  assign shift_val = present[tc] ? (pcount - CNT_W'(1) - CNT_W'(shift_rd)) : pcount;
  assign index_w = IX_W'(pos) + IX_W'(1) - IX_W'(pcount);

  hss_ram #(.WIDTH(BW), .DEPTH(PATTERN_MAX), .AW(PA_W)) u_pattern_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pbase[PA_W-1:0]),
    .wdata (byte_value),
    .re    (state == S_READ),
    .raddr (pat_raddr_w[PA_W-1:0]),
    .rdata (pat_rd)
  );

  hss_ram #(.WIDTH(BW), .DEPTH(TEXT_MAX), .AW(TA_W)) u_text_ram (
    .clk   (clk),
    .we    (text_we),
    .waddr (tcount[TA_W-1:0]),
    .wdata (byte_value),
    .re    (state == S_READ),
    .raddr (text_raddr_w[TA_W-1:0]),
    .rdata (text_rd)
  );

  // holds the rightmost position of each byte value in all but the last
  // pattern byte; the shift is derived from it at search time
  hss_ram #(.WIDTH(PA_W), .DEPTH(hss_pkg::ALPHABET), .AW(BW)) u_shift_ram (
    .clk   (clk),
    .we    (shift_we),
    .waddr (prev_byte),
    .wdata (PA_W'(pbase - CNT_W'(1))),
    .re    (cmp_re),
    .raddr (text_rd),
    .rdata (shift_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pcount <= '0;
      tcount <= '0;
      complete <= 1'b0;
      overflow <= 1'b0;
      present <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc && kind == hss_pkg::KIND_PATTERN) begin
            if (pat_we) begin
              pcount <= pbase + CNT_W'(1);
            end else begin
              pcount <= CNT_W'(PATTERN_MAX + 1);
            end
            if (shift_we) begin
              present <= (complete ? '0 : present)
                         | (hss_pkg::ALPHABET'(1) << prev_byte);
            end else if (complete) begin
              present <= '0;
            end
            prev_byte <= byte_value;
            complete <= last;
          end else if (acc) begin
            if (text_we) begin
              tcount <= tcount + TC_W'(1);
            end else begin
              overflow <= 1'b1;
            end
            if (last) begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          pos <= POS_W'(pcount - CNT_W'(1));
          if (!complete || pcount == '0 || pcount > CNT_W'(PATTERN_MAX) || overflow) begin
            res_status <= hss_pkg::STATUS_ERROR;
            res_index <= '0;
            state <= S_DONE;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          k <= '0;
          if (pos < POS_W'(tcount)) begin
            state <= S_READ;
          end else begin
            res_status <= hss_pkg::STATUS_NOT_FOUND;
            res_index <= '0;
            state <= S_DONE;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (k == '0) begin
            tc <= text_rd;
          end
          if (text_rd == pat_rd) begin
            if (k + CNT_W'(1) == pcount) begin
              res_status <= hss_pkg::STATUS_FOUND;
              res_index <= index_w[hss_pkg::INDEX_W-1:0];
              state <= S_DONE;
            end else begin
              k <= k + CNT_W'(1);
              state <= S_READ;
            end
          end else begin
            state <= S_ADV;
          end
        end
        S_ADV: begin
          // advance by the table shift of the window's last text byte
          pos <= pos + POS_W'(shift_val);
          state <= S_CHK;
        end
        S_DONE: begin
          if (out_free) begin
            status <= res_status;
            match_index <= res_index;
            tcount <= '0;
            overflow <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/hss_ram.sv =====
module hss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== tb/sv/horspool_substring_search_unit_tb.sv =====
module horspool_substring_search_unit_tb;
  import hss_pkg::*;

  localparam int PAT_DEPTH = PATTERN_MAX_DEF;
  localparam int TXT_DEPTH = TEXT_MAX_DEF;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_ITEMS = 1400;

  typedef struct {
    logic                kind;
    logic [BYTE_W-1:0]   value;
    logic                closes;
    int                  gap;
    bit                  drain;
  } byte_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  index;
  } search_result_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                kind = KIND_PATTERN;
  logic [BYTE_W-1:0]   byte_value = '0;
  logic                last = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  match_index;

  horspool_substring_search_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .byte_value  (byte_value),
    .last        (last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .match_index (match_index)
  );

  // Mirror of the block's storage.
  logic [BYTE_W-1:0] pat_mem [PAT_DEPTH];
  logic [BYTE_W-1:0] txt_mem [TXT_DEPTH];
  int                skip_len [ALPHABET];
  bit                skip_valid [ALPHABET];
  int                pat_len = 0;
  int                txt_len = 0;
  bit                pat_done = 1'b0;
  bit                txt_ovf = 1'b0;

  search_result_t    search_answers[$];
  byte_req_t         byte_queue[$];
  logic [BYTE_W-1:0] scratch[$];
  logic [BYTE_W-1:0] cur_pat[$];

  int total_queued = 0;
  int bytes_accepted = 0;
  int burst_left = 0;
  int gap_count = 0;
  int searches_sent = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  int stall_span = 0;
  int stall_level = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Horspool scan over the mirrored text; returns 1 with the start index on a hit.
  function automatic bit horspool_scan(output int where);
    int m;
    int n;
    int pos;
    int k;
    m = pat_len;
    n = txt_len;
    pos = m - 1;
    where = 0;
    while (pos < n) begin
      k = 0;
      while (k < m && txt_mem[pos-k] == pat_mem[m-1-k]) k++;
      if (k == m) begin
        where = pos + 1 - m;
        return 1'b1;
      end
      pos += skip_valid[txt_mem[pos]] ? skip_len[txt_mem[pos]] : m;
    end
    return 1'b0;
  endfunction

  function automatic void absorb_byte(logic is_text, logic [BYTE_W-1:0] b, logic closes);
    search_result_t ans;
    int where;
    if (is_text == KIND_PATTERN) begin
      if (pat_done) begin
        pat_done = 1'b0;
        pat_len = 0;
        foreach (skip_valid[c]) skip_valid[c] = 1'b0;
      end
      if (pat_len < PAT_DEPTH) begin
        pat_mem[pat_len] = b;
        pat_len++;
      end else begin
        pat_len = PAT_DEPTH + 1;
      end
      if (closes) begin
        pat_done = 1'b1;
        if (pat_len <= PAT_DEPTH) begin
          foreach (skip_valid[c]) skip_valid[c] = 1'b0;
          for (int i = 0; i + 1 < pat_len; i++) begin
            skip_len[pat_mem[i]] = pat_len - 1 - i;
            skip_valid[pat_mem[i]] = 1'b1;
          end
        end
      end
      return;
    end
    if (txt_len < TXT_DEPTH) begin
      txt_mem[txt_len] = b;
      txt_len++;
    end else begin
      txt_ovf = 1'b1;
    end
    if (!closes) return;
    ans.index = '0;
    if (!pat_done || pat_len == 0 || pat_len > PAT_DEPTH || txt_ovf) begin
      ans.status = STATUS_ERROR;
    end else if (horspool_scan(where)) begin
      ans.status = STATUS_FOUND;
      ans.index = INDEX_W'(where);
    end else begin
      ans.status = STATUS_NOT_FOUND;
    end
    search_answers.push_back(ans);
    txt_len = 0;
    txt_ovf = 1'b0;
  endfunction

  task automatic queue_byte(input logic k, input logic [BYTE_W-1:0] v, input logic closes,
                            input bit drain);
    byte_req_t req;
    req.kind = k;
    req.value = v;
    req.closes = closes;
    req.drain = drain;
    req.gap = 0;
    // Start a new burst after a random gap; some bursts are long enough to run unthrottled.
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 30);
      req.gap = $urandom_range(1, 12);
    end
    burst_left--;
    byte_queue.push_back(req);
    total_queued++;
  endtask

  task automatic queue_run(input logic k, input bit drain);
    foreach (scratch[i]) queue_byte(k, scratch[i], i == scratch.size() - 1, drain && i == 0);
  endtask

  function automatic logic [BYTE_W-1:0] pick_char(bit small_alpha);
    if (small_alpha) return BYTE_W'(8'h61 + $urandom_range(0, 2));
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  always @(posedge clk) begin : drive_requests
    byte_req_t req;
    logic keep_valid;
    bit took_search;
    keep_valid = in_valid;
    took_search = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        absorb_byte(kind, byte_value, last);
        bytes_accepted++;
        took_search = (kind == KIND_TEXT) && last;
        if (took_search) searches_sent <= searches_sent + 1;
        keep_valid = 1'b0;
      end
      if (!keep_valid && byte_queue.size() > 0) begin
        if (gap_count < byte_queue[0].gap) begin
          gap_count++;
        end else if (!byte_queue[0].drain || searches_sent + took_search == results_seen) begin
          req = byte_queue.pop_front();
          kind <= req.kind;
          byte_value <= req.value;
          last <= req.closes;
          keep_valid = 1'b1;
          gap_count = 0;
        end
      end
    end
    in_valid <= keep_valid;
  end

  always @(posedge clk) begin : check_results
    search_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (search_answers.size() == 0) begin
          $error("result with no search pending: status %0d, match_index %0d",
                 status, match_index);
          mismatch_count++;
        end else begin
          want = search_answers.pop_front();
          if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            mismatch_count++;
          end
          if (match_index !== want.index) begin
            $error("match_index mismatch: expected %0d, actual %0d", want.index, match_index);
            mismatch_count++;
          end
        end
      end
      // Change the stall density at random intervals; level 0 never stalls.
      if (stall_span == 0) begin
        stall_span = $urandom_range(20, 300);
        stall_level = $urandom_range(0, 3);
      end else begin
        stall_span--;
      end
      out_stall <= (stall_level != 0) && ($urandom_range(0, 3) < stall_level);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int random_start;
    int len;
    int pick;
    int pos;
    bit small_alpha;

    // Search before any pattern exists.
    scratch = '{8'h41};
    queue_run(KIND_TEXT, 1'b0);
    // Search while a pattern is still open.
    queue_byte(KIND_PATTERN, 8'h00, 1'b0, 1'b0);
    queue_run(KIND_TEXT, 1'b0);
    queue_byte(KIND_PATTERN, 8'hFF, 1'b0, 1'b0);
    queue_byte(KIND_PATTERN, 8'h00, 1'b1, 1'b0);
    scratch = '{8'hFF, 8'h00, 8'hFF, 8'h00};
    queue_run(KIND_TEXT, 1'b0);
    // New pattern arrives in the middle of a text.
    queue_byte(KIND_TEXT, 8'h00, 1'b0, 1'b0);
    queue_byte(KIND_PATTERN, 8'hAB, 1'b1, 1'b0);
    queue_byte(KIND_TEXT, 8'hAB, 1'b1, 1'b0);
    // Pattern longer than text, then a plain miss.
    scratch = '{8'h01, 8'h02, 8'h03};
    queue_run(KIND_PATTERN, 1'b0);
    scratch = '{8'h03};
    queue_run(KIND_TEXT, 1'b0);
    scratch = '{8'h12, 8'h34, 8'h56};
    queue_run(KIND_TEXT, 1'b0);

    // Too-long pattern.
    scratch.delete();
    for (int i = 0; i < PAT_DEPTH + 2; i++) scratch.push_back(BYTE_W'(i * 3));
    queue_run(KIND_PATTERN, 1'b0);
    scratch = '{8'h00};
    queue_run(KIND_TEXT, 1'b0);
    // Full-size pattern found at offset 3.
    scratch.delete();
    for (int i = 0; i < PAT_DEPTH; i++) scratch.push_back(BYTE_W'(i) ^ 8'h5A);
    queue_run(KIND_PATTERN, 1'b0);
    scratch = '{8'h00, 8'hFF, 8'h10};
    for (int i = 0; i < PAT_DEPTH; i++) scratch.push_back(BYTE_W'(i) ^ 8'h5A);
    scratch.push_back(8'h10);
    queue_run(KIND_TEXT, 1'b0);

    random_start = total_queued;
    // Hold the first random request until the directed searches have all answered.
    queue_byte(KIND_PATTERN, 8'h62, 1'b1, 1'b1);
    cur_pat = '{8'h62};
    while (total_queued - random_start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        small_alpha = $urandom_range(0, 3) != 0;
        if ($urandom_range(0, 2) == 0) begin
          pick = $urandom_range(0, 19);
          if (pick < 14) len = $urandom_range(1, 6);
          else if (pick < 19) len = $urandom_range(7, PAT_DEPTH);
          else len = $urandom_range(PAT_DEPTH + 1, PAT_DEPTH + 6);
          scratch.delete();
          for (int i = 0; i < len; i++) scratch.push_back(pick_char(small_alpha));
          cur_pat = scratch;
          queue_run(KIND_PATTERN, $urandom_range(0, 49) == 0);
        end
        len = $urandom_range(1, cur_pat.size() > 8 ? 80 : 40);
        scratch.delete();
        for (int i = 0; i < len; i++) scratch.push_back(pick_char(small_alpha));
        if ($urandom_range(0, 1) == 1 && cur_pat.size() <= len) begin
          pos = $urandom_range(0, len - cur_pat.size());
          foreach (cur_pat[j]) scratch[pos+j] = cur_pat[j];
        end
        queue_run(KIND_TEXT, $urandom_range(0, 49) == 0);
      end else begin
        // Noise: loose bytes of either kind.
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
          queue_byte(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)),
                     $urandom_range(0, 2) == 0, 1'b0);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (bytes_accepted != total_queued) @(posedge clk);
    while (search_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== horspool_substring_search_unit.f =====
src/hss_pkg.sv
src/hss_ram.sv
src/horspool_substring_search_unit.sv
tb/sv/horspool_substring_search_unit_tb.sv
